// File: src/coefficient_bit_unpacker_top_macros.svh
// Assertion macros shared by the checker of the coefficient unpacker.
`ifndef COEFFICIENT_BIT_UNPACKER_TOP_MACROS_SVH
`define COEFFICIENT_BIT_UNPACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after reset is sampled.
`define CBU_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cbu_pkg.sv
// Package with the types and constants of the coefficient unpacker.
`timescale 1ns / 1ps
package cbu_pkg;

    localparam int COEF_W            = 31;
    localparam int WIDTH_W           = 5;
    localparam int BUF_BITS          = 62;
    localparam int CNT_W             = 6;
    localparam int WORD_W            = 32;
    localparam int OUT_W             = 32;
    localparam int DEF_MAX_COEF_BITS = 31;
    localparam int MIN_COEF_BITS     = 2;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_COEF_BITS   = 1'b0;
    localparam logic CFG_SIGN_EXTEND = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] coef_bits;
        logic               sign_extend;
    } t_cfg;

    typedef struct packed {
        logic [COEF_W-1:0]  raw;
        logic [WIDTH_W-1:0] width;
        logic               sext;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic   vld0;
        logic   vld1;
        t_entry e0;
        t_entry e1;
    } t_push;

endpackage

// File: src/cbu_front.sv
// Front end: accepts words, keeps the residual bit buffer and cuts out coefficients.
`timescale 1ns / 1ps
module cbu_front #(
    parameter int P_MAX_COEF_BITS = cbu_pkg::DEF_MAX_COEF_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cbu_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic [cbu_pkg::WORD_W-1:0] i_word,
    input  logic                       i_first,
    input  logic                       i_room,
    output logic                       o_ready,
    output cbu_pkg::t_push             o_push
);
    import cbu_pkg::*;

    logic [BUF_BITS-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic [WIDTH_W-1:0]  w;
    logic [CNT_W:0]      w7, w2;
    logic [BUF_BITS-1:0] eff_buf, nb, sh1, sh2;
    logic [CNT_W-1:0]    eff_cnt, nc;
    logic [CNT_W:0]      sum;
    logic [63:0]         shifted;
    logic [COEF_W-1:0]   mask;
    logic                have0, have1, accept;

    assign o_ready = i_room;
    assign accept  = i_valid & i_room;

    always_comb begin
        if (i_cfg.coef_bits < WIDTH_W'(MIN_COEF_BITS)) begin
            w = WIDTH_W'(MIN_COEF_BITS);
        end else if (i_cfg.coef_bits > WIDTH_W'(P_MAX_COEF_BITS)) begin
            w = WIDTH_W'(P_MAX_COEF_BITS);
        end else begin
            w = i_cfg.coef_bits;
        end
        w7      = {2'b00, w};
        w2      = w7 << 1;
        eff_buf = i_first ? '0 : r_buf;
        eff_cnt = i_first ? '0 : r_cnt;
        shifted = {32'b0, i_word} << eff_cnt;
        nb      = eff_buf | shifted[BUF_BITS-1:0];
        sum     = {1'b0, eff_cnt} + (CNT_W+1)'(WORD_W);
        nc      = (sum > (CNT_W+1)'(BUF_BITS)) ? CNT_W'(BUF_BITS) : sum[CNT_W-1:0];
        have0   = {1'b0, nc} >= w7;
        have1   = {1'b0, nc} >= w2;
        sh1     = nb >> w;
        sh2     = nb >> w2;
        mask    = COEF_W'((33'h1 << w) - 33'h1);

        o_push.vld0     = accept & have0;
        o_push.vld1     = accept & have1;
        o_push.e0.raw   = nb[COEF_W-1:0] & mask;
        o_push.e0.width = w;
        o_push.e0.sext  = i_cfg.sign_extend;
        o_push.e0.last  = ~have1;
        o_push.e1.raw   = sh1[COEF_W-1:0] & mask;
        o_push.e1.width = w;
        o_push.e1.sext  = i_cfg.sign_extend;
        o_push.e1.last  = 1'b1;

        n_buf = r_buf;
        n_cnt = r_cnt;
        if (accept) begin
            if (have1) begin
                n_buf = sh2;
                n_cnt = nc - w2[CNT_W-1:0];
            end else if (have0) begin
                n_buf = sh1;
                n_cnt = nc - {1'b0, w};
            end else begin
                n_buf = nb;
                n_cnt = nc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            r_buf <= n_buf;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: src/cbu_queue.sv
// Short queue between front and back; takes up to two entries and gives one per cycle while popped.
`timescale 1ns / 1ps
module cbu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cbu_pkg::t_push  i_push,
    output logic            o_room,
    input  logic            i_pop,
    output logic            o_nonempty,
    output cbu_pkg::t_entry o_head
);
    import cbu_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_pop;

    assign o_room     = r_cnt <= QCNT_W'(QUEUE_DEPTH - 2);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rd];
    assign do_pop     = i_pop & o_nonempty;

    always_comb begin
        n_wr  = r_wr + QPTR_W'(i_push.vld0) + QPTR_W'(i_push.vld1);
        n_rd  = r_rd + QPTR_W'(do_pop);
        n_cnt = r_cnt + QCNT_W'(i_push.vld0) + QCNT_W'(i_push.vld1) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.vld1) begin
            r_mem[r_wr + QPTR_W'(1)] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: src/cbu_back.sv
// Back end: extends each coefficient to 32 bits and holds it in the output register.
`timescale 1ns / 1ps
module cbu_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_nonempty,
    input  cbu_pkg::t_entry           i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cbu_pkg::OUT_W-1:0] o_data,
    output logic                      o_last
);
    import cbu_pkg::*;

    logic              r_valid, n_valid;
    logic [OUT_W-1:0]  r_data, n_data;
    logic              r_last, n_last;
    logic [OUT_W-1:0]  mask;
    logic [OUT_W-1:0]  ext;
    logic [WIDTH_W-1:0] top_bit;

    assign o_pop   = i_nonempty & (~r_valid | i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

    always_comb begin
        mask    = OUT_W'((33'h1 << i_head.width) - 33'h1);
        top_bit = i_head.width - WIDTH_W'(1);
        ext     = {1'b0, i_head.raw};
        if (i_head.sext && i_head.raw[top_bit]) begin
            ext = ext | ~mask;
        end
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        if (o_pop) begin
            n_valid = 1'b1;
            n_data  = ext;
            n_last  = i_head.last;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

endmodule

// File: src/coefficient_bit_unpacker_top.sv
// Top level of the 32-to-N bit unpacker for packed polynomial coefficients.
`timescale 1ns / 1ps
// The front takes each 32-bit word, appends it to a 62-bit residual buffer and cuts out
// up to two coefficients at once, which enter a four-entry queue. The input is ready
// whenever that queue has room for two entries, so a word can enter every cycle while it
// does. Results leave one per cycle while the output is ready, through the queue and then
// a registered output; the output port therefore sets the sustained rate at one coefficient
// per cycle, so widths that yield two coefficients from most words take words more slowly
// than that. Configuration is written through a plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module coefficient_bit_unpacker_top #(
    parameter int P_MAX_COEF_BITS = cbu_pkg::DEF_MAX_COEF_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [cbu_pkg::WIDTH_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [cbu_pkg::WORD_W-1:0] s_axis_tdata,  // [31:0] word
    input  logic                       s_axis_tuser,  // [0] first
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [cbu_pkg::OUT_W-1:0]  m_axis_tdata,  // [31:0] coefficient
    output logic                       m_axis_tlast
);
    import cbu_pkg::*;

    t_cfg   r_cfg;
    t_push  push;
    t_entry head;
    logic   room, nonempty, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_bits   <= WIDTH_W'(31);
            r_cfg.sign_extend <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_COEF_BITS:   r_cfg.coef_bits   <= i_cfg_wdata;
                CFG_SIGN_EXTEND: r_cfg.sign_extend <= i_cfg_wdata[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    cbu_front #(
        .P_MAX_COEF_BITS(P_MAX_COEF_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_word  (s_axis_tdata),
        .i_first (s_axis_tuser),
        .i_room  (room),
        .o_ready (s_axis_tready),
        .o_push  (push)
    );

    cbu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room     (room),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    cbu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

// File: src/cbu_checker.sv
// Port-level assertions for the coefficient unpacker and their bind to the top level.
`timescale 1ns / 1ps
`include "coefficient_bit_unpacker_top_macros.svh"
module cbu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `CBU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
        "stalled output item changed")

    `CBU_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, !m_axis_tvalid && s_axis_tready,
        "block not idle after reset")

    `CBU_ASSERT_NOW(a_out_from_word, i_clk, i_rst_n, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready, 2),
        "output appeared without an accepted word two cycles before")

endmodule

bind coefficient_bit_unpacker_top cbu_checker u_cbu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
